>>> hw/rtl/rafd_pkg.sv
// types, codes and frame layout constants for the radio api frame decoder
package rafd_pkg;

    localparam logic [7:0] DELIM = 8'h7E;
    localparam logic [7:0] SUM_GOOD = 8'hFF;
    localparam logic [7:0] MAX_PAYLOAD = 8'd128;

    localparam logic [7:0] RESET_RX_CODE = 8'h90;
    localparam logic [7:0] RESET_MODEM_CODE = 8'h8A;
    localparam logic [7:0] RESET_TX_CODE = 8'h89;
    localparam logic [7:0] RESET_EXT_CODE = 8'h8B;
    localparam logic [7:0] RESET_AT_CODE = 8'h88;

    localparam logic [7:0] CFG_RX_CODE = 8'd0;
    localparam logic [7:0] CFG_MODEM_CODE = 8'd1;
    localparam logic [7:0] CFG_TX_CODE = 8'd2;
    localparam logic [7:0] CFG_EXT_CODE = 8'd3;
    localparam logic [7:0] CFG_AT_CODE = 8'd4;

    localparam logic [15:0] MIN_LEN_RX = 16'd12;
    localparam logic [15:0] MIN_LEN_MODEM = 16'd2;
    localparam logic [15:0] MIN_LEN_TX = 16'd3;
    localparam logic [15:0] MIN_LEN_EXT = 16'd6;
    localparam logic [15:0] MIN_LEN_AT = 16'd5;

    localparam logic [15:0] POS_ADDR_FIRST = 16'd1;
    localparam logic [15:0] POS_ADDR_LAST = 16'd8;
    localparam logic [15:0] POS_RX_OPTIONS = 16'd11;
    localparam logic [15:0] POS_RX_PAYLOAD = 16'd12;
    localparam logic [15:0] POS_IDENT = 16'd1;
    localparam logic [15:0] POS_MODEM_STATUS = 16'd1;
    localparam logic [15:0] POS_TX_STATUS = 16'd2;
    localparam logic [15:0] POS_EXT_RETRY = 16'd4;
    localparam logic [15:0] POS_EXT_STATUS = 16'd5;
    localparam logic [15:0] POS_AT_STATUS = 16'd4;
    localparam logic [15:0] POS_AT_PAYLOAD = 16'd5;

    typedef enum logic [1:0] {
        OUTCOME_OK       = 2'd0,
        OUTCOME_BAD_SUM  = 2'd1,
        OUTCOME_BAD_TYPE = 2'd2,
        OUTCOME_BAD_LEN  = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_RX,
        KIND_MODEM,
        KIND_TX,
        KIND_EXT,
        KIND_AT
    } kind_t;

    typedef enum logic [1:0] {
        HDR_LEN_HI,
        HDR_LEN_LO,
        HDR_BODY
    } hdr_t;

    typedef struct packed {
        logic [7:0] rx_code;
        logic [7:0] modem_code;
        logic [7:0] tx_code;
        logic [7:0] ext_code;
        logic [7:0] at_code;
    } codes_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        frame_end;
        outcome_t    outcome;
        logic [7:0]  api_type;
        logic [63:0] source_address;
        logic [7:0]  rx_options;
        logic [7:0]  frame_ident;
        logic [7:0]  delivery_status;
        logic [7:0]  tx_retries;
        logic [7:0]  payload_length;
    } result_t;

    function automatic kind_t kind_of(input logic [7:0] t, input codes_t c);
        kind_t k;
        if (t == c.rx_code) k = KIND_RX;
        else if (t == c.modem_code) k = KIND_MODEM;
        else if (t == c.tx_code) k = KIND_TX;
        else if (t == c.ext_code) k = KIND_EXT;
        else if (t == c.at_code) k = KIND_AT;
        else k = KIND_NONE;
        return k;
    endfunction

endpackage

>>> hw/rtl/radio_api_frame_decoder.sv
// radio api frame decoder: delimiter hunt, header, field capture, checksum and summary
//
// Takes one received byte per item and accepts a byte every clock, with the
// decision for each byte made combinationally by the byte-position decode
// between the input port and the result register. A payload byte or frame
// summary shows on the m_ side the cycle after its byte is accepted; the
// next byte is taken in the same cycle that a waiting result is taken, so a
// stalled result channel holds the input only while the result register is
// full and not being drained. Type codes come from five 8-bit registers on
// the cfg port (index 0 to 4); writes to other indexes are ignored.
module radio_api_frame_decoder
    import rafd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_payload_byte,
    output logic        m_frame_end,
    output logic [1:0]  m_outcome,
    output logic [7:0]  m_api_type,
    output logic [63:0] m_source_address,
    output logic [7:0]  m_rx_options,
    output logic [7:0]  m_frame_ident,
    output logic [7:0]  m_delivery_status,
    output logic [7:0]  m_tx_retries,
    output logic [7:0]  m_payload_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    codes_t      codes_reg;
    logic        in_frame_reg, in_frame_next;
    hdr_t        hdr_reg, hdr_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  type_reg, type_next;
    logic [63:0] addr_reg, addr_next;
    logic [7:0]  opt_reg, opt_next;
    logic [7:0]  ident_reg, ident_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  retry_reg, retry_next;
    logic [7:0]  count_reg, count_next;
    logic        m_valid_reg;
    result_t     res_reg;
    result_t     res;
    logic        res_valid;
    logic        s_accept;
    logic [7:0]  sum_new;
    logic [7:0]  type_eff;
    kind_t       kind;
    kind_t       end_kind;
    logic [15:0] min_len;
    logic [16:0] max_len;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg.rx_code <= RESET_RX_CODE;
            codes_reg.modem_code <= RESET_MODEM_CODE;
            codes_reg.tx_code <= RESET_TX_CODE;
            codes_reg.ext_code <= RESET_EXT_CODE;
            codes_reg.at_code <= RESET_AT_CODE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RX_CODE:    codes_reg.rx_code <= cfg_data;
                CFG_MODEM_CODE: codes_reg.modem_code <= cfg_data;
                CFG_TX_CODE:    codes_reg.tx_code <= cfg_data;
                CFG_EXT_CODE:   codes_reg.ext_code <= cfg_data;
                CFG_AT_CODE:    codes_reg.at_code <= cfg_data;
                default: ;
            endcase
        end
    end

    assign sum_new = sum_reg + s_rx_byte;
    assign type_eff = (pos_reg == 16'd0) ? s_rx_byte : type_reg;
    assign kind = kind_of(type_eff, codes_reg);
    assign end_kind = (len_reg == 16'd0) ? KIND_NONE : kind_of(type_reg, codes_reg);

    always_comb begin
        unique case (end_kind)
            KIND_RX: begin
                min_len = MIN_LEN_RX;
                max_len = 17'({8'd0, MAX_PAYLOAD}) + 17'(MIN_LEN_RX);
            end
            KIND_MODEM: begin
                min_len = MIN_LEN_MODEM;
                max_len = 17'h1FFFF;
            end
            KIND_TX: begin
                min_len = MIN_LEN_TX;
                max_len = 17'h1FFFF;
            end
            KIND_EXT: begin
                min_len = MIN_LEN_EXT;
                max_len = 17'h1FFFF;
            end
            KIND_AT: begin
                min_len = MIN_LEN_AT;
                max_len = 17'({8'd0, MAX_PAYLOAD}) + 17'(MIN_LEN_AT);
            end
            default: begin
                min_len = 16'd0;
                max_len = 17'h1FFFF;
            end
        endcase
    end

    always_comb begin
        in_frame_next = in_frame_reg;
        hdr_next = hdr_reg;
        pos_next = pos_reg;
        len_next = len_reg;
        sum_next = sum_reg;
        type_next = type_reg;
        addr_next = addr_reg;
        opt_next = opt_reg;
        ident_next = ident_reg;
        status_next = status_reg;
        retry_next = retry_reg;
        count_next = count_reg;
        res = '0;
        res_valid = 1'b0;
        if (s_accept) begin
            if (!in_frame_reg) begin
                if (s_rx_byte == DELIM) begin
                    in_frame_next = 1'b1;
                    hdr_next = HDR_LEN_HI;
                    pos_next = '0;
                    len_next = '0;
                    sum_next = '0;
                    type_next = '0;
                    addr_next = '0;
                    opt_next = '0;
                    ident_next = '0;
                    status_next = '0;
                    retry_next = '0;
                    count_next = '0;
                end
            end else begin
                unique case (hdr_reg)
                    HDR_LEN_HI: begin
                        len_next = {s_rx_byte, 8'h00};
                        hdr_next = HDR_LEN_LO;
                    end
                    HDR_LEN_LO: begin
                        len_next = {len_reg[15:8], s_rx_byte};
                        hdr_next = HDR_BODY;
                        pos_next = '0;
                    end
                    HDR_BODY: begin
                        sum_next = sum_new;
                        if (pos_reg >= len_reg) begin
                            // checksum byte closes the frame
                            res_valid = 1'b1;
                            res.frame_end = 1'b1;
                            if (sum_new != SUM_GOOD) res.outcome = OUTCOME_BAD_SUM;
                            else if (len_reg == 16'd0) res.outcome = OUTCOME_BAD_LEN;
                            else if (end_kind == KIND_NONE) res.outcome = OUTCOME_BAD_TYPE;
                            else if (len_reg < min_len || {1'b0, len_reg} > max_len)
                                res.outcome = OUTCOME_BAD_LEN;
                            else res.outcome = OUTCOME_OK;
                            res.api_type = (len_reg == 16'd0) ? 8'd0 : type_reg;
                            if (end_kind == KIND_RX) begin
                                res.source_address = addr_reg;
                                res.rx_options = opt_reg;
                            end
                            if (end_kind == KIND_TX || end_kind == KIND_EXT)
                                res.frame_ident = ident_reg;
                            if (end_kind != KIND_NONE && end_kind != KIND_RX)
                                res.delivery_status = status_reg;
                            if (end_kind == KIND_EXT) res.tx_retries = retry_reg;
                            res.payload_length = count_reg;
                            in_frame_next = 1'b0;
                            hdr_next = HDR_LEN_HI;
                        end else begin
                            type_next = type_eff;
                            pos_next = pos_reg + 16'd1;
                            case (kind)
                                KIND_RX: begin
                                    if (pos_reg >= POS_ADDR_FIRST && pos_reg <= POS_ADDR_LAST)
                                        addr_next = {addr_reg[55:0], s_rx_byte};
                                    else if (pos_reg == POS_RX_OPTIONS) opt_next = s_rx_byte;
                                end
                                KIND_MODEM: begin
                                    if (pos_reg == POS_MODEM_STATUS) status_next = s_rx_byte;
                                end
                                KIND_TX: begin
                                    if (pos_reg == POS_IDENT) ident_next = s_rx_byte;
                                    else if (pos_reg == POS_TX_STATUS) status_next = s_rx_byte;
                                end
                                KIND_EXT: begin
                                    if (pos_reg == POS_IDENT) ident_next = s_rx_byte;
                                    else if (pos_reg == POS_EXT_RETRY) retry_next = s_rx_byte;
                                    else if (pos_reg == POS_EXT_STATUS) status_next = s_rx_byte;
                                end
                                KIND_AT: begin
                                    if (pos_reg == POS_AT_STATUS) status_next = s_rx_byte;
                                end
                                default: ;
                            endcase
                            if (((kind == KIND_RX && pos_reg >= POS_RX_PAYLOAD) ||
                                 (kind == KIND_AT && pos_reg >= POS_AT_PAYLOAD)) &&
                                count_reg < MAX_PAYLOAD) begin
                                count_next = count_reg + 8'd1;
                                res_valid = 1'b1;
                                res.payload_byte = s_rx_byte;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            hdr_reg <= HDR_LEN_HI;
            pos_reg <= '0;
            len_reg <= '0;
            sum_reg <= '0;
            type_reg <= '0;
            addr_reg <= '0;
            opt_reg <= '0;
            ident_reg <= '0;
            status_reg <= '0;
            retry_reg <= '0;
            count_reg <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            hdr_reg <= hdr_next;
            pos_reg <= pos_next;
            len_reg <= len_next;
            sum_reg <= sum_next;
            type_reg <= type_next;
            addr_reg <= addr_next;
            opt_reg <= opt_next;
            ident_reg <= ident_next;
            status_reg <= status_next;
            retry_reg <= retry_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_payload_byte = res_reg.payload_byte;
    assign m_frame_end = res_reg.frame_end;
    assign m_outcome = res_reg.outcome;
    assign m_api_type = res_reg.api_type;
    assign m_source_address = res_reg.source_address;
    assign m_rx_options = res_reg.rx_options;
    assign m_frame_ident = res_reg.frame_ident;
    assign m_delivery_status = res_reg.delivery_status;
    assign m_tx_retries = res_reg.tx_retries;
    assign m_payload_length = res_reg.payload_length;

    // payload items carry nothing but the data byte
    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !res_reg.frame_end |->
            res_reg.payload_length == 8'd0 && res_reg.outcome == OUTCOME_OK &&
            res_reg.api_type == 8'd0)
        else $error("payload item with summary fields set");

    // summary items never carry a data byte
    a_summary_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.frame_end |-> res_reg.payload_byte == 8'd0)
        else $error("summary item with nonzero data byte");

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_PAYLOAD)
        else $error("payload count past limit");

    // a summary closes the frame and returns to delimiter hunt
    a_summary_leaves_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && res_valid && res.frame_end |=> !in_frame_reg && hdr_reg == HDR_LEN_HI)
        else $error("frame still open after summary");

    // results only come from body bytes of an open frame
    a_result_in_body: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> in_frame_reg && hdr_reg == HDR_BODY && s_accept)
        else $error("result outside frame body");

endmodule

>>> test/tb_top.sv
// testbench for radio_api_frame_decoder: random frame streams checked against a byte-level decoder model
module tb_top;
    import rafd_pkg::*;

    localparam logic [7:0] CFG_PAST_LIST = 8'd5;
    localparam logic [7:0] CFG_INDEX_TOP = 8'hFF;
    localparam int HOLD_CYCLES = 300;
    localparam int RUN_LIMIT = 20_000_000;

    class frame_tracker;
        codes_t      codes;
        bit          in_frame;
        hdr_t        hdr;
        logic [15:0] pos;
        logic [15:0] len;
        logic [7:0]  sum;
        logic [7:0]  ftype;
        logic [63:0] addr;
        logic [7:0]  opts;
        logic [7:0]  ident;
        logic [7:0]  status;
        logic [7:0]  retry;
        logic [7:0]  count;
        result_t     pending_results[$];
        int          errors;

        function new();
            codes = {RESET_RX_CODE, RESET_MODEM_CODE, RESET_TX_CODE, RESET_EXT_CODE,
                     RESET_AT_CODE};
            in_frame = 1'b0;
            errors = 0;
            clear();
        endfunction

        function void clear();
            hdr = HDR_LEN_HI;
            pos = '0;
            len = '0;
            sum = '0;
            ftype = '0;
            addr = '0;
            opts = '0;
            ident = '0;
            status = '0;
            retry = '0;
            count = '0;
        endfunction

        function kind_t classify(logic [7:0] t);
            if (t == codes.rx_code) return KIND_RX;
            if (t == codes.modem_code) return KIND_MODEM;
            if (t == codes.tx_code) return KIND_TX;
            if (t == codes.ext_code) return KIND_EXT;
            if (t == codes.at_code) return KIND_AT;
            return KIND_NONE;
        endfunction

        function void set_code(logic [7:0] idx, logic [7:0] v);
            case (idx)
                CFG_RX_CODE: codes.rx_code = v;
                CFG_MODEM_CODE: codes.modem_code = v;
                CFG_TX_CODE: codes.tx_code = v;
                CFG_EXT_CODE: codes.ext_code = v;
                CFG_AT_CODE: codes.at_code = v;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void take_byte(logic [7:0] b);
            kind_t       k;
            result_t     r;
            logic [15:0] minlen;
            logic [15:0] plen;
            if (!in_frame) begin
                if (b == DELIM) begin
                    in_frame = 1'b1;
                    clear();
                end
                return;
            end
            if (hdr == HDR_LEN_HI) begin
                len = {b, 8'h00};
                hdr = HDR_LEN_LO;
                return;
            end
            if (hdr == HDR_LEN_LO) begin
                len[7:0] = b;
                hdr = HDR_BODY;
                pos = '0;
                return;
            end
            sum = sum + b;
            r = '0;
            if (pos >= len) begin
                k = (len == 0) ? KIND_NONE : classify(ftype);
                minlen = '0;
                plen = '0;
                case (k)
                    KIND_RX: begin
                        minlen = MIN_LEN_RX;
                        if (len >= MIN_LEN_RX) plen = len - MIN_LEN_RX;
                    end
                    KIND_MODEM: minlen = MIN_LEN_MODEM;
                    KIND_TX: minlen = MIN_LEN_TX;
                    KIND_EXT: minlen = MIN_LEN_EXT;
                    KIND_AT: begin
                        minlen = MIN_LEN_AT;
                        if (len >= MIN_LEN_AT) plen = len - MIN_LEN_AT;
                    end
                    default: ;
                endcase
                r.frame_end = 1'b1;
                if (sum != SUM_GOOD) r.outcome = OUTCOME_BAD_SUM;
                else if (len == 0) r.outcome = OUTCOME_BAD_LEN;
                else if (k == KIND_NONE) r.outcome = OUTCOME_BAD_TYPE;
                else if (len < minlen || plen > MAX_PAYLOAD) r.outcome = OUTCOME_BAD_LEN;
                else r.outcome = OUTCOME_OK;
                r.api_type = (len == 0) ? 8'h00 : ftype;
                if (k == KIND_RX) begin
                    r.source_address = addr;
                    r.rx_options = opts;
                end
                if (k == KIND_TX || k == KIND_EXT) r.frame_ident = ident;
                if (k != KIND_NONE && k != KIND_RX) r.delivery_status = status;
                if (k == KIND_EXT) r.tx_retries = retry;
                r.payload_length = count;
                pending_results.push_back(r);
                in_frame = 1'b0;
                hdr = HDR_LEN_HI;
                return;
            end
            if (pos == 0) ftype = b;
            k = classify(ftype);
            case (k)
                KIND_RX: begin
                    if (pos >= POS_ADDR_FIRST && pos <= POS_ADDR_LAST) addr = {addr[55:0], b};
                    else if (pos == POS_RX_OPTIONS) opts = b;
                end
                KIND_MODEM: begin
                    if (pos == POS_MODEM_STATUS) status = b;
                end
                KIND_TX: begin
                    if (pos == POS_IDENT) ident = b;
                    else if (pos == POS_TX_STATUS) status = b;
                end
                KIND_EXT: begin
                    if (pos == POS_IDENT) ident = b;
                    else if (pos == POS_EXT_RETRY) retry = b;
                    else if (pos == POS_EXT_STATUS) status = b;
                end
                KIND_AT: begin
                    if (pos == POS_AT_STATUS) status = b;
                end
                default: ;
            endcase
            if (((k == KIND_RX && pos >= POS_RX_PAYLOAD) || (k == KIND_AT && pos >= POS_AT_PAYLOAD))
                && count < MAX_PAYLOAD) begin
                count = count + 8'd1;
                r.payload_byte = b;
                pending_results.push_back(r);
            end
            pos = pos + 16'd1;
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %h, got %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                $error("unexpected item: frame_end %0d payload_byte %h", got.frame_end,
                       got.payload_byte);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            check_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
            check_field("frame_end", 64'(want.frame_end), 64'(got.frame_end));
            check_field("outcome", 64'(want.outcome), 64'(got.outcome));
            check_field("api_type", 64'(want.api_type), 64'(got.api_type));
            check_field("source_address", want.source_address, got.source_address);
            check_field("rx_options", 64'(want.rx_options), 64'(got.rx_options));
            check_field("frame_ident", 64'(want.frame_ident), 64'(got.frame_ident));
            check_field("delivery_status", 64'(want.delivery_status),
                        64'(got.delivery_status));
            check_field("tx_retries", 64'(want.tx_retries), 64'(got.tx_retries));
            check_field("payload_length", 64'(want.payload_length), 64'(got.payload_length));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_payload_byte;
    logic        m_frame_end;
    logic [1:0]  m_outcome;
    logic [7:0]  m_api_type;
    logic [63:0] m_source_address;
    logic [7:0]  m_rx_options;
    logic [7:0]  m_frame_ident;
    logic [7:0]  m_delivery_status;
    logic [7:0]  m_tx_retries;
    logic [7:0]  m_payload_length;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'h00;
    logic [7:0]  cfg_data = 8'h00;

    frame_tracker tracker = new();
    bit idling_on = 1'b1;
    bit hold_req = 1'b0;
    int bytes_sent = 0;

    radio_api_frame_decoder uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_rx_byte(s_rx_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_payload_byte(m_payload_byte),
        .m_frame_end(m_frame_end),
        .m_outcome(m_outcome),
        .m_api_type(m_api_type),
        .m_source_address(m_source_address),
        .m_rx_options(m_rx_options),
        .m_frame_ident(m_frame_ident),
        .m_delivery_status(m_delivery_status),
        .m_tx_retries(m_tx_retries),
        .m_payload_length(m_payload_length),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin : result_monitor
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.payload_byte = m_payload_byte;
            got.frame_end = m_frame_end;
            got.outcome = outcome_t'(m_outcome);
            got.api_type = m_api_type;
            got.source_address = m_source_address;
            got.rx_options = m_rx_options;
            got.frame_ident = m_frame_ident;
            got.delivery_status = m_delivery_status;
            got.tx_retries = m_tx_retries;
            got.payload_length = m_payload_length;
            tracker.check_result(got);
        end
    end

    initial begin : result_side
        wait (aresetn);
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (idling_on && $urandom_range(0, 11) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("** radio_api_frame_decoder: FAILED **");
        $finish;
    end

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 254));
        if (b >= DELIM) b = b + 8'd1;
        return b;
    endfunction

    function automatic int frame_size(input logic [15:0] minlen, input bit carries_payload);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return $urandom_range(1, minlen - 1);
        if (carries_payload && roll < 14) return minlen + $urandom_range(124, 140);
        return minlen + $urandom_range(0, carries_payload ? 24 : 3);
    endfunction

    task automatic put_byte(input logic [7:0] b);
        if (idling_on && $urandom_range(0, 11) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        tracker.take_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] ftype, input int body_len, input int len_extra,
                              input bit bad_sum);
        logic [15:0] declared;
        logic [7:0]  b;
        logic [7:0]  total;
        // finish off a frame left open by an overstated length
        while (tracker.in_frame) put_byte(noise_byte());
        declared = 16'(body_len + len_extra);
        put_byte(DELIM);
        put_byte(declared[15:8]);
        put_byte(declared[7:0]);
        total = 8'h00;
        for (int i = 0; i < body_len; i++) begin
            b = (i == 0) ? ftype : 8'($urandom_range(0, 255));
            total = total + b;
            put_byte(b);
        end
        b = SUM_GOOD - total;
        if (bad_sum) b = b + 8'($urandom_range(1, 255));
        put_byte(b);
    endtask

    task automatic random_frame();
        int         pick;
        int         body_len;
        int         extra;
        bit         bad_sum;
        logic [7:0] t;
        pick = $urandom_range(0, 99);
        extra = ($urandom_range(0, 24) == 0) ? $urandom_range(1, 5) : 0;
        bad_sum = ($urandom_range(0, 11) == 0);
        t = 8'h00;
        if (pick < 25) begin
            t = tracker.codes.rx_code;
            body_len = frame_size(MIN_LEN_RX, 1'b1);
        end else if (pick < 45) begin
            t = tracker.codes.at_code;
            body_len = frame_size(MIN_LEN_AT, 1'b1);
        end else if (pick < 55) begin
            t = tracker.codes.modem_code;
            body_len = frame_size(MIN_LEN_MODEM, 1'b0);
        end else if (pick < 65) begin
            t = tracker.codes.tx_code;
            body_len = frame_size(MIN_LEN_TX, 1'b0);
        end else if (pick < 75) begin
            t = tracker.codes.ext_code;
            body_len = frame_size(MIN_LEN_EXT, 1'b0);
        end else if (pick < 87) begin
            do t = 8'($urandom_range(0, 255)); while (tracker.classify(t) != KIND_NONE);
            body_len = $urandom_range(1, 8);
        end else if (pick < 90) begin
            body_len = 0;
        end else begin
            repeat ($urandom_range(1, 4)) put_byte(noise_byte());
            return;
        end
        send_frame(t, body_len, extra, bad_sum);
    endtask

    task automatic run_random(input int upto);
        while (bytes_sent < upto) random_frame();
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_code(idx, v);
    endtask

    task automatic set_codes(input logic [7:0] stray, input logic [7:0] rx,
                             input logic [7:0] modem, input logic [7:0] tx,
                             input logic [7:0] ext, input logic [7:0] at);
        wait_idle();
        cfg_write(stray, 8'($urandom_range(0, 255)));
        cfg_write(CFG_RX_CODE, rx);
        cfg_write(CFG_MODEM_CODE, modem);
        cfg_write(CFG_TX_CODE, tx);
        cfg_write(CFG_EXT_CODE, ext);
        cfg_write(CFG_AT_CODE, at);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset type codes
        put_byte(8'h00);
        put_byte(8'hFF);
        send_frame(8'h00, 0, 0, 1'b0);
        send_frame(RESET_MODEM_CODE, int'(MIN_LEN_MODEM), 0, 1'b0);
        send_frame(RESET_TX_CODE, int'(MIN_LEN_TX), 0, 1'b1);
        send_frame(RESET_EXT_CODE, int'(MIN_LEN_EXT), 0, 1'b0);
        send_frame(RESET_AT_CODE, MIN_LEN_AT + 3, 0, 1'b0);
        send_frame(RESET_RX_CODE, MIN_LEN_RX + 2, 0, 1'b0);
        send_frame(8'h55, 1, 0, 1'b0);
        send_frame(RESET_RX_CODE, MIN_LEN_RX - 1, 0, 1'b0);

        set_codes(CFG_PAST_LIST, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
        hold_req = 1'b1;
        // payload right at the limit, then one past it
        send_frame(tracker.codes.at_code, int'(MIN_LEN_AT) + int'(MAX_PAYLOAD), 0, 1'b0);
        send_frame(tracker.codes.rx_code, MIN_LEN_RX + MAX_PAYLOAD + 1, 0, 1'b0);
        run_random(650);

        // shared codes: earlier match wins
        set_codes(CFG_INDEX_TOP, 8'h00, 8'h00, 8'hFF, DELIM, 8'hFF);
        run_random(1000);

        set_codes(CFG_PAST_LIST, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h00);
        run_random(1300);

        set_codes(CFG_INDEX_TOP, RESET_RX_CODE, RESET_MODEM_CODE, RESET_TX_CODE,
                  RESET_EXT_CODE, RESET_AT_CODE);
        run_random(1550);
        idling_on = 1'b0;
        run_random(1850);

        wait_idle();
        repeat (8) @(posedge aclk);
        if (tracker.errors == 0) begin
            $display("** radio_api_frame_decoder: PASSED **");
        end else begin
            $display("** radio_api_frame_decoder: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/rafd_pkg.sv
hw/rtl/radio_api_frame_decoder.sv
test/tb_top.sv
